[rtl/core/vce_pkg.sv]
package vce_pkg;

  localparam int unsigned MaxVertices = 16;
  localparam int unsigned MaxEdges    = 64;

  localparam int unsigned CmdW      = 2;
  localparam int unsigned EdgeIdxW  = 6;
  localparam int unsigned VertW     = 4;
  localparam int unsigned MaskW     = 16;
  localparam int unsigned SizeW     = 5;
  localparam int unsigned VcntW     = 5;
  localparam int unsigned EcntW     = 7;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 7;
  localparam int unsigned EdgeDataW = 2 * VertW;

  localparam logic [CfgIdxW-1:0] RegVertexCount = 1'd0;
  localparam logic [CfgIdxW-1:0] RegEdgeCount   = 1'd1;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_NEXT    = 2'd2
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    logic wr_edge;   // store the item's edge
    logic restart;   // put the cursor at the full set
    logic start;     // load the first candidate of a search
    logic set_done;  // result is "no cover left"
    logic scan;      // check edges against the candidate
    logic emit;      // move the result into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic finished;  // walk is over
    logic scan_end;  // cover found or subsets exhausted
    logic out_free;  // output register can take a result now
  } dp_status_t;

  // Order mask (vertex 0 as the most significant of n bits) to a vertex mask.
  function automatic logic [MaskW-1:0] order_to_vertices(logic [MaskW-1:0] m,
                                                         logic [VcntW-1:0] n);
    logic [MaskW-1:0] v;
    logic [VcntW-1:0] k;
    v = '0;
    for (int i = 0; i < MaskW; i++) begin
      k = VcntW'(n - VcntW'(i) - VcntW'(1));
      if (VcntW'(i) < n) begin
        v[i] = m[k[VertW-1:0]];
      end
    end
    return v;
  endfunction

  function automatic logic [SizeW-1:0] pop_count(logic [MaskW-1:0] v);
    logic [SizeW-1:0] c;
    c = '0;
    for (int i = 0; i < MaskW; i++) begin
      c = c + SizeW'(v[i]);
    end
    return c;
  endfunction

endpackage

[rtl/core/vce_ram.sv]
module vce_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/vce_ctrl.sv]
module vce_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [vce_pkg::CmdW-1:0]     cmd_i,
  output logic                         in_stall_o,
  input  vce_pkg::dp_status_t          status_i,
  output vce_pkg::ctrl_cmd_t           cmd_o
);
  import vce_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            CMD_LOAD:    cmd_o.wr_edge = 1'b1;
            CMD_RESTART: cmd_o.restart = 1'b1;
            CMD_NEXT: begin
              if (status_i.finished) begin
                cmd_o.set_done = 1'b1;
                state_d        = ST_EMIT;
              end else begin
                cmd_o.start = 1'b1;
                state_d     = ST_SCAN;
              end
            end
            default: ;  // unused command: drop the item
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_end) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/vce_datapath.sv]
module vce_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [vce_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [vce_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic [vce_pkg::EdgeIdxW-1:0]     edge_index_i,
  input  logic [vce_pkg::VertW-1:0]        end_a_i,
  input  logic [vce_pkg::VertW-1:0]        end_b_i,
  input  vce_pkg::ctrl_cmd_t               cmd_i,
  output vce_pkg::dp_status_t              status_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [vce_pkg::MaskW-1:0]        cover_mask_o,
  output logic [vce_pkg::SizeW-1:0]        cover_size_o,
  output logic                             done_res_o
);
  import vce_pkg::*;

  logic [VcntW-1:0]     vcnt_q, vcnt_d;
  logic [EcntW-1:0]     ecnt_q, ecnt_d;
  logic [MaskW-1:0]     cursor_q, cursor_d;
  logic                 finished_q, finished_d;
  logic [MaskW-1:0]     m_q, m_d;
  logic [EcntW-1:0]     idx_q, idx_d;
  logic                 chk_q, chk_d;
  logic [MaskW-1:0]     res_v_q, res_v_d;
  logic                 res_done_q, res_done_d;
  logic                 out_valid_q, out_valid_d;
  logic [MaskW-1:0]     out_mask_q;
  logic [SizeW-1:0]     out_size_q;
  logic                 out_done_q;

  logic [VcntW-1:0]     n_eff;
  logic [EcntW-1:0]     e_eff;
  logic [MaskW-1:0]     top;
  logic [MaskW-1:0]     cur_sat;
  logic [MaskW-1:0]     vmask;
  logic [EdgeDataW-1:0] edge_rd;
  logic                 covered;
  logic                 issue;
  logic                 fail;
  logic                 pass;
  logic                 out_free;

  assign n_eff   = (vcnt_q > VcntW'(MaxVertices)) ? VcntW'(MaxVertices) : vcnt_q;
  assign e_eff   = (ecnt_q > EcntW'(MaxEdges)) ? EcntW'(MaxEdges) : ecnt_q;
  assign top     = MaskW'((17'd1 << n_eff) - 17'd1);
  assign cur_sat = (cursor_q > top) ? top : cursor_q;
  assign vmask   = order_to_vertices(m_q, n_eff);

  vce_ram #(
    .Width (EdgeDataW),
    .Depth (MaxEdges)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_edge),
    .waddr_i (edge_index_i),
    .wdata_i ({end_b_i, end_a_i}),
    .re_i    (cmd_i.scan && issue),
    .raddr_i (idx_q[EdgeIdxW-1:0]),
    .rdata_o (edge_rd)
  );

  // endpoints at or above the vertex count read as zero bits of vmask
  assign covered = vmask[edge_rd[VertW-1:0]] || vmask[edge_rd[EdgeDataW-1:VertW]];
  assign issue   = (idx_q < e_eff);
  assign fail    = chk_q && !covered;
  assign pass    = !chk_q && !issue;

  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.finished = finished_q;
  assign status_o.scan_end = pass || (fail && (m_q == '0));
  assign status_o.out_free = out_free;

  always_comb begin
    vcnt_d      = vcnt_q;
    ecnt_d      = ecnt_q;
    cursor_d    = cursor_q;
    finished_d  = finished_q;
    m_d         = m_q;
    idx_d       = idx_q;
    chk_d       = chk_q;
    res_v_d     = res_v_q;
    res_done_d  = res_done_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegVertexCount: vcnt_d = cfg_wdata_i[VcntW-1:0];
        RegEdgeCount:   ecnt_d = cfg_wdata_i;
        default: ;
      endcase
    end

    if (cmd_i.restart) begin
      cursor_d   = top;
      finished_d = 1'b0;
    end

    if (cmd_i.start) begin
      m_d   = cur_sat;
      idx_d = '0;
      chk_d = 1'b0;
    end

    if (cmd_i.set_done) begin
      res_v_d    = '0;
      res_done_d = 1'b1;
    end

    if (cmd_i.scan) begin
      if (fail) begin
        if (m_q == '0) begin
          res_v_d    = '0;
          res_done_d = 1'b1;
          finished_d = 1'b1;
          cursor_d   = '0;
        end else begin
          // drop the read in flight and advance to the next subset
          m_d   = m_q - MaskW'(1);
          idx_d = '0;
          chk_d = 1'b0;
        end
      end else if (pass) begin
        res_v_d    = vmask;
        res_done_d = 1'b0;
        if (m_q == '0) begin
          finished_d = 1'b1;
        end else begin
          cursor_d = m_q - MaskW'(1);
        end
      end else begin
        idx_d = idx_q + EcntW'(issue);
        chk_d = issue;
      end
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q      <= '0;
      ecnt_q      <= '0;
      cursor_q    <= '0;
      finished_q  <= 1'b1;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      vcnt_q      <= vcnt_d;
      ecnt_q      <= ecnt_d;
      cursor_q    <= cursor_d;
      finished_q  <= finished_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q        <= m_d;
    idx_q      <= idx_d;
    res_v_q    <= res_v_d;
    res_done_q <= res_done_d;
    if (cmd_i.emit) begin
      out_mask_q <= res_v_q;
      out_size_q <= pop_count(res_v_q);
      out_done_q <= res_done_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cover_mask_o = out_mask_q;
  assign cover_size_o = out_size_q;
  assign done_res_o   = out_done_q;

endmodule

[rtl/core/vertex_cover_enumerator_core.sv]
// Vertex cover enumerator. Load edges into the 64-entry edge store, send a
// restart item, then send next items: each returns the following vertex subset
// (walked from the full set down to the empty set, vertex 0 as the most
// significant bit of the walk order) that touches every edge below the edge
// count, or done_res once no cover remains. Load and restart items give no
// result. A next item tests one subset after another; the edge store has one
// registered read port, so one edge is checked per cycle and each subset waits
// for its first read. A next item that finds the walk over returns done_res.
// Either result also waits while an earlier result still sits stalled in the
// output register. Results wait in an output register; load and restart items
// are still taken while a result waits there.
module vertex_cover_enumerator_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [vce_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [vce_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [vce_pkg::CmdW-1:0]         cmd_i,
  input  logic [vce_pkg::EdgeIdxW-1:0]     edge_index_i,
  input  logic [vce_pkg::VertW-1:0]        end_a_i,
  input  logic [vce_pkg::VertW-1:0]        end_b_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [vce_pkg::MaskW-1:0]        cover_mask_o,
  output logic [vce_pkg::SizeW-1:0]        cover_size_o,
  output logic                             done_res_o
);
  import vce_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  vce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  vce_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .edge_index_i (edge_index_i),
    .end_a_i      (end_a_i),
    .end_b_i      (end_b_i),
    .cmd_i        (ctrl_cmd),
    .status_o     (dp_status),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cover_mask_o (cover_mask_o),
    .cover_size_o (cover_size_o),
    .done_res_o   (done_res_o)
  );

endmodule

[rtl/core/vce_checker.sv]
module vce_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [vce_pkg::MaskW-1:0]        cover_mask_o,
  input logic [vce_pkg::SizeW-1:0]        cover_size_o,
  input logic                             done_res_o
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(cover_mask_o) && $stable(cover_size_o)
                                   && $stable(done_res_o))
    else $error("stalled result changed");

  // a done result carries an empty cover
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> (cover_mask_o == '0) && (cover_size_o == '0))
    else $error("done result with nonempty cover");

  // size must match the reported mask
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> 32'(cover_size_o) == $countones(cover_mask_o))
    else $error("cover size does not match cover mask");

endmodule

bind vertex_cover_enumerator_core vce_checker u_vce_checker (.*);
